>>> hw/rtl/twt_pkg.sv
// shared constants and types for the trapped water total block
package twt_pkg;

    // default store depth and stored height width
    localparam int MAX_BARS_DEF    = 1024;
    localparam int HEIGHT_BITS_DEF = 16;

    // fixed widths of the port fields
    localparam int HEIGHT_IN_BITS = 16;
    localparam int TOTAL_BITS     = 26;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_BWAIT,
        ST_FWD,
        ST_FWAIT
    } twt_state_t;

endpackage

>>> hw/rtl/trapped_water_total_top.sv
// trapped water total: row loading, right peak pass and accumulating pass
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------
//  input    | start / busy       | height, last
//  result   | done (one cycle)   | water_sum, too_many
//
// heights are taken one per cycle while busy is low; the first MAX_BARS are stored
// the beat with last set makes busy high through these steps (n stored heights):
//   a backward pass over the height ram filling the right peak ram, a gap state,
//   a forward pass reading both rams and accumulating, and a closing state
// done is high in the first cycle with busy low; a new start is taken in that cycle
// reset clears the sequencer, row count and control flags; the rams are not cleared
// the receiver cannot stall, so a result is never held
module trapped_water_total_top #(
    parameter int MAX_BARS    = twt_pkg::MAX_BARS_DEF,
    parameter int HEIGHT_BITS = twt_pkg::HEIGHT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [twt_pkg::HEIGHT_IN_BITS-1:0] height,
    input  logic                            last,
    output logic                            done,
    output logic [twt_pkg::TOTAL_BITS-1:0]  water_sum,
    output logic                            too_many
);

    localparam int AW  = $clog2(MAX_BARS);
    localparam int CW  = $clog2(MAX_BARS + 1);
    localparam int HIN = (HEIGHT_BITS < twt_pkg::HEIGHT_IN_BITS) ?
                         HEIGHT_BITS : twt_pkg::HEIGHT_IN_BITS;
    localparam int SW  = ((HEIGHT_BITS > twt_pkg::TOTAL_BITS) ?
                          HEIGHT_BITS : twt_pkg::TOTAL_BITS) + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BARS);

    twt_pkg::twt_state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   b_valid_reg, b_valid_next;
    logic [AW-1:0]          b_idx_reg, b_idx_next;
    logic                   f_valid_reg, f_valid_next;
    logic [HEIGHT_BITS-1:0] run_max_reg, run_max_next;
    logic [HEIGHT_BITS-1:0] left_reg, left_next;
    logic [twt_pkg::TOTAL_BITS-1:0] sum_reg, sum_next;
    logic                   done_reg, done_next;
    logic [twt_pkg::TOTAL_BITS-1:0] total_reg, total_next;
    logic                   too_many_reg, too_many_next;

    logic                   accept;
    logic                   store_en;
    logic [HEIGHT_BITS-1:0] h_in;
    logic [CW-1:0]          n_m1;
    logic                   h_rd_en;
    logic                   rp_rd_en;
    logic [HEIGHT_BITS-1:0] h_rd;
    logic [HEIGHT_BITS-1:0] rp_rd;
    logic [HEIGHT_BITS-1:0] rp_wr;
    logic [HEIGHT_BITS-1:0] left_upd;
    logic [HEIGHT_BITS-1:0] lim;
    logic [HEIGHT_BITS-1:0] diff;
    logic [SW-1:0]          sum_ext;
    logic [twt_pkg::TOTAL_BITS-1:0] sum_acc;

    // input beat and store write
    assign accept   = start && !busy;
    assign store_en = accept && (count_reg < CNT_FULL);
    assign h_in     = HEIGHT_BITS'(height[HIN-1:0]);
    assign n_m1     = count_reg - CW'(1);

    // height store
    assign h_rd_en = (state_reg == twt_pkg::ST_BACK) || (state_reg == twt_pkg::ST_FWD);

    twt_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_BARS)
    ) u_height_ram (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (h_in),
        .rd_en   (h_rd_en),
        .rd_addr (idx_reg),
        .rd_data (h_rd)
    );

    // right peak store, written by the backward pass
    assign rp_wr    = (h_rd > run_max_reg) ? h_rd : run_max_reg;
    assign rp_rd_en = (state_reg == twt_pkg::ST_FWD);

    twt_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_BARS)
    ) u_peak_ram (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_idx_reg),
        .wr_data (rp_wr),
        .rd_en   (rp_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rp_rd)
    );

    // forward accumulate with saturation
    assign left_upd = (h_rd > left_reg) ? h_rd : left_reg;
    assign lim      = (left_upd < rp_rd) ? left_upd : rp_rd;
    assign diff     = lim - h_rd;
    assign sum_ext  = SW'(sum_reg) + SW'(diff);
    assign sum_acc  = (sum_ext > SW'(twt_pkg::TOTAL_MAX)) ?
                      twt_pkg::TOTAL_MAX : sum_ext[twt_pkg::TOTAL_BITS-1:0];

    // state register and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= twt_pkg::ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            b_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            b_valid_reg  <= b_valid_next;
            f_valid_reg  <= f_valid_next;
            done_reg     <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        b_idx_reg    <= b_idx_next;
        run_max_reg  <= run_max_next;
        left_reg     <= left_next;
        sum_reg      <= sum_next;
        total_reg    <= total_next;
        too_many_reg <= too_many_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        b_valid_next  = 1'b0;
        b_idx_next    = idx_reg;
        f_valid_next  = 1'b0;
        run_max_next  = run_max_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        done_next     = 1'b0;
        total_next    = total_reg;
        too_many_next = too_many_reg;

        // backward pass write stage keeps the running peak
        if (b_valid_reg)
        begin
            run_max_next = rp_wr;
        end

        // forward pass accumulate stage
        if (f_valid_reg)
        begin
            left_next = left_upd;
            sum_next  = sum_acc;
        end

        case (state_reg)
            twt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_en)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        idx_next     = count_next[AW-1:0] - AW'(1);
                        run_max_next = '0;
                        state_next   = twt_pkg::ST_BACK;
                    end
                end
            end
            twt_pkg::ST_BACK:
            begin
                b_valid_next = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = twt_pkg::ST_BWAIT;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            twt_pkg::ST_BWAIT:
            begin
                // last peak write lands here, before the forward reads
                idx_next   = '0;
                left_next  = '0;
                sum_next   = '0;
                state_next = twt_pkg::ST_FWD;
            end
            twt_pkg::ST_FWD:
            begin
                f_valid_next = 1'b1;
                if (idx_reg == n_m1[AW-1:0])
                begin
                    state_next = twt_pkg::ST_FWAIT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            twt_pkg::ST_FWAIT:
            begin
                total_next    = sum_next;
                too_many_next = ovf_reg;
                done_next     = 1'b1;
                count_next    = '0;
                ovf_next      = 1'b0;
                state_next    = twt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = twt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy        = (state_reg != twt_pkg::ST_IDLE);
    assign done        = done_reg;
    assign water_sum   = total_reg;
    assign too_many    = too_many_reg;

    // result strobe only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // a stored height advances the row count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last && (count_reg < CNT_FULL)) |=>
            (count_reg == $past(count_reg) + CW'(1)))
        else $error("row count did not advance on stored height");

    // right peak read back is never below the wall at that position
    a_peak_ok: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> (rp_rd >= h_rd))
        else $error("right peak below wall height, stale peak store read");

    // the backward pass finishes before the forward reads begin
    a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twt_pkg::ST_FWD) |-> !b_valid_reg)
        else $error("peak store write overlapping forward pass");

endmodule

>>> hw/rtl/twt_ram.sv
// generic single write port, single read port ram with registered read
module twt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sim/trapped_water_total_checker.sv
`timescale 1ns / 1ps
// row predictor and result comparison for the trapped water total block
module trapped_water_total_checker #(
    parameter int MAX_BARS    = twt_pkg::MAX_BARS_DEF,
    parameter int HEIGHT_BITS = twt_pkg::HEIGHT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [twt_pkg::HEIGHT_IN_BITS-1:0] height,
    input  logic                               last,
    input  logic                               done,
    input  logic [twt_pkg::TOTAL_BITS-1:0]     water_sum,
    input  logic                               too_many,
    output int                                 mismatches,
    output int                                 rows_pending
);

    typedef struct packed {
        logic [twt_pkg::TOTAL_BITS-1:0] water;
        logic                           dropped;
    } row_total_t;

    // heights of the row being loaded, as the block keeps them
    logic [HEIGHT_BITS-1:0] row_heights [MAX_BARS];
    int unsigned            heights_held;
    logic                   heights_dropped;
    row_total_t             totals_due [$];
    row_total_t             oldest;

    // water over the inner positions of the first n stored heights
    function automatic logic [twt_pkg::TOTAL_BITS-1:0] water_held(input int unsigned n);
        logic [HEIGHT_BITS-1:0] peak_right [MAX_BARS];
        logic [HEIGHT_BITS-1:0] peak_left;
        logic [HEIGHT_BITS-1:0] rim;
        longint unsigned        sum;
        int                     k;
        sum = 0;
        if (n < 3)
            return '0;
        // highest wall from each position to the row end
        peak_right[n-1] = row_heights[n-1];
        for (k = n - 2; k >= 0; k--)
        begin
            peak_right[k] = (row_heights[k] > peak_right[k+1]) ? row_heights[k]
                                                               : peak_right[k+1];
        end
        // walk forward keeping the highest wall so far
        peak_left = row_heights[0];
        for (k = 1; k < n - 1; k++)
        begin
            if (row_heights[k] > peak_left)
                peak_left = row_heights[k];
            rim = (peak_left < peak_right[k]) ? peak_left : peak_right[k];
            sum += rim - row_heights[k];
            if (sum > twt_pkg::TOTAL_MAX)
                sum = twt_pkg::TOTAL_MAX;
        end
        return sum[twt_pkg::TOTAL_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heights_held    = 0;
            heights_dropped = 1'b0;
            totals_due.delete();
            rows_pending    = 0;
        end
        else
        begin
            // result beat against the oldest row total due
            if (done)
            begin
                if (totals_due.size() == 0)
                begin
                    $display("%0t: result beat with none due: water_sum %0d too_many %0b",
                             $time, water_sum, too_many);
                    mismatches++;
                end
                else
                begin
                    oldest = totals_due.pop_front();
                    if (water_sum !== oldest.water || too_many !== oldest.dropped)
                    begin
                        $display("%0t: expected water_sum %0d too_many %0b, got %0d %0b",
                                 $time, oldest.water, oldest.dropped, water_sum, too_many);
                        mismatches++;
                    end
                end
            end
            // input beat into the row store, dropped once the store is full
            if (start && !busy)
            begin
                if (heights_held < MAX_BARS)
                begin
                    row_heights[heights_held] = HEIGHT_BITS'(height);
                    heights_held++;
                end
                else
                    heights_dropped = 1'b1;
                if (last)
                begin
                    totals_due.push_back(row_total_t'{water_held(heights_held),
                                                      heights_dropped});
                    heights_held    = 0;
                    heights_dropped = 1'b0;
                end
            end
            rows_pending = totals_due.size();
        end
    end

endmodule

>>> sim/trapped_water_total_top_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the trapped water total block
module trapped_water_total_top_tb;

    typedef enum int {
        HP_FULL,
        HP_LOW,
        HP_EXTREME,
        HP_MID
    } height_profile_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [twt_pkg::HEIGHT_IN_BITS-1:0] height;
    logic                               last;
    logic                               done;
    logic [twt_pkg::TOTAL_BITS-1:0]     water_sum;
    logic                               too_many;
    int                                 mismatches;
    int                                 rows_pending;
    int                                 idle_pct;

    // the textbook valley row, six units of water
    logic [twt_pkg::HEIGHT_IN_BITS-1:0] valley_row [12] =
        '{0, 1, 0, 2, 1, 0, 1, 3, 2, 1, 2, 1};

    trapped_water_total_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .height     (height),
        .last       (last),
        .done       (done),
        .water_sum  (water_sum),
        .too_many   (too_many)
    );

    trapped_water_total_checker water_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .height      (height),
        .last        (last),
        .done        (done),
        .water_sum   (water_sum),
        .too_many    (too_many),
        .mismatches  (mismatches),
        .rows_pending(rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [twt_pkg::HEIGHT_IN_BITS-1:0] pick_height(
        input height_profile_t profile);
        case (profile)
            HP_FULL:    return twt_pkg::HEIGHT_IN_BITS'($urandom_range(65535));
            HP_LOW:     return twt_pkg::HEIGHT_IN_BITS'($urandom_range(15));
            HP_EXTREME: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default:    return twt_pkg::HEIGHT_IN_BITS'($urandom_range(4095));
        endcase
    endfunction

    // one input beat, entered and left at a falling edge, with random idle cycles first
    task automatic send_height(input logic [twt_pkg::HEIGHT_IN_BITS-1:0] h, input logic fin);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start  <= 1'b0;
            height <= twt_pkg::HEIGHT_IN_BITS'($urandom);
            last   <= 1'($urandom);
            @(negedge clk);
        end
        start  <= 1'b1;
        height <= h;
        last   <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_row(input int len, input height_profile_t profile);
        for (int i = 0; i < len; i++)
            send_height(pick_height(profile), i == len - 1);
    endtask

    // hold off until every row total has come back
    task automatic drain_rows;
        start <= 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
    endtask

    task automatic random_rows(input int pct, input int quota);
        int              sent;
        int              len;
        height_profile_t profile;
        idle_pct = pct;
        sent     = 0;
        while (sent < quota)
        begin
            len     = ($urandom_range(99) < 70) ? $urandom_range(12, 1)
                                                : $urandom_range(48, 13);
            profile = height_profile_t'($urandom_range(3));
            send_row(len, profile);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        height   = '0;
        last     = 1'b0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short rows, the tallest walls around a hole and a peak between floors
        send_height(16'hFFFF, 1'b1);
        send_height(16'h0000, 1'b0);
        send_height(16'hFFFF, 1'b1);
        send_height(16'hFFFF, 1'b0);
        send_height(16'h0000, 1'b0);
        send_height(16'hFFFF, 1'b1);
        send_height(16'h0000, 1'b0);
        send_height(16'hFFFF, 1'b0);
        send_height(16'h0000, 1'b1);
        for (int i = 0; i < 12; i++)
            send_height(valley_row[i], i == 11);
        drain_rows();
        @(negedge clk);

        // random rows with and without sender gaps
        random_rows(0, 75);
        random_rows(50, 75);
        drain_rows();
        @(negedge clk);

        // a completely full store with the final height dropped
        random_rows(0, 75);
        send_row(twt_pkg::MAX_BARS_DEF + 1, HP_EXTREME);
        drain_rows();
        @(negedge clk);
        random_rows(38, 75);

        // wind down and give the verdict
        drain_rows();
        repeat (16) @(negedge clk);
        if (mismatches == 0 && rows_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
